>>> src/bisection_cubic_root_finder_macros.svh
// Assertion macros for the bisection cubic root finder.
`ifndef BISECTION_CUBIC_ROOT_FINDER_MACROS_SVH
`define BISECTION_CUBIC_ROOT_FINDER_MACROS_SVH

`ifndef SYNTHESIS
`define BCRF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcrf assertion failed");
`define BCRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcrf assertion failed");
`else
`define BCRF_ASSERT_SAME(label, clk, rst, ante, cons)
`define BCRF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/bcrf_pkg.sv
// Types, codes and reset constants of the bisection cubic root finder.
package bcrf_pkg;

   localparam int MAX_ITER_DEFAULT  = 64;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEFF_CONSTANT = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEFF_LINEAR   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEFF_SQUARE   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEFF_CUBE     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE      = 3'd4;

   localparam logic signed [31:0] COEFF_CONSTANT_RESET = -32'sd196608;
   localparam logic signed [31:0] COEFF_LINEAR_RESET   = 32'sd277437;
   localparam logic signed [31:0] COEFF_SQUARE_RESET   = -32'sd88474;
   localparam logic signed [31:0] COEFF_CUBE_RESET     = 32'sd7646;
   localparam logic [31:0]        TOLERANCE_RESET      = 32'd66;

   localparam logic [1:0] STATUS_CONVERGED  = 2'd0;
   localparam logic [1:0] STATUS_EXACT_ZERO = 2'd1;
   localparam logic [1:0] STATUS_NO_CHANGE  = 2'd2;
   localparam logic [1:0] STATUS_ITER_LIMIT = 2'd3;

   localparam logic [1:0] SIGN_ZERO = 2'b00;
   localparam logic [1:0] SIGN_POS  = 2'b01;
   localparam logic [1:0] SIGN_NEG  = 2'b11;

   localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

   typedef struct packed {
      logic signed [31:0] left_end;
      logic signed [31:0] right_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] root;
      logic [6:0]         iterations;
      logic [31:0]        last_step;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAG,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_SAT,
      ST_ADD,
      ST_DECIDE,
      ST_MID,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      EV_LOW,
      EV_HIGH,
      EV_MID
   } eval_type;

endpackage

>>> src/bisection_cubic_root_finder.sv
// A cubic evaluation runs three Horner steps, each through ST_MAG, ST_MUL_LO, ST_MUL_HI, ST_SUM,
// ST_SAT and ST_ADD, then a sign decision. A search evaluates both ends, then for each of n
// bisection steps (n <= MAX_ITER) forms the midpoint in ST_MID and evaluates it; ST_DONE loads
// the output register once it is free. One item at a time: the next is taken in the cycle after
// the result loads. A single shared 32x32 multiplier is used twice a product.
// Reset (synchronous): control returns to idle, coefficients and tolerance to defaults.
`include "bisection_cubic_root_finder_macros.svh"

module bisection_cubic_root_finder #(
   parameter int MAX_ITER  = bcrf_pkg::MAX_ITER_DEFAULT,
   parameter int FRAC_BITS = bcrf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  bcrf_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output bcrf_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_write_enable,
   input  logic [bcrf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bcrf_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam logic [95:0] ROUND_MASK = {{(96-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

   // configuration
   logic signed [31:0] coeff_constant_ff, coeff_linear_ff, coeff_square_ff, coeff_cube_ff;
   logic [31:0]        tolerance_ff;

   // sequencer and datapath
   bcrf_pkg::state_type state_ff, state_in;
   bcrf_pkg::eval_type  eval_ff, eval_in;
   logic [1:0]          term_ff, term_in;
   logic signed [31:0]  low_ff, low_in, high_ff, high_in, prev_ff, prev_in, x_ff, x_in;
   logic [31:0]         xmag_ff, xmag_in;
   logic [1:0]          low_sign_ff, low_sign_in, high_sign_ff, high_sign_in;
   logic [6:0]          count_ff, count_in;
   logic signed [63:0]  acc_ff, acc_in;
   logic [63:0]         mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [63:0]         plo_ff, plo_in, phi_ff, phi_in;
   logic [95:0]         sum_ff, sum_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic [31:0]         step_ff, step_in;
   logic signed [31:0]  root_ff, root_in;
   logic [1:0]          status_ff, status_in;
   bcrf_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic               req_take;
   logic               rsp_free;
   logic [31:0]        mul_op;
   logic [63:0]        mul_res;
   logic [95:0]        qmag;
   logic               q_ovf;
   logic signed [31:0] coeff_sel;
   logic signed [64:0] add_wide;
   logic signed [32:0] mid_sum;
   logic [1:0]         acc_sign;
   logic               move_low, move_high;
   logic signed [32:0] diff;
   logic [32:0]        diff_abs;
   logic               converged, at_limit, no_change;

   function automatic logic same_sign(input logic [1:0] a, input logic [1:0] b);
      return (a != bcrf_pkg::SIGN_ZERO) && (a == b);
   endfunction

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != bcrf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // shared multiplier: low half then high half of the accumulator magnitude
   assign mul_op  = (state_ff == bcrf_pkg::ST_MUL_LO) ? mag_ff[31:0] : mag_ff[63:32];
   assign mul_res = 64'(mul_op) * 64'(xmag_ff);

   assign qmag  = sum_ff >> FRAC_BITS;
   assign q_ovf = |qmag[95:63];

   always_comb begin
      case (term_ff)
         2'd0:    coeff_sel = coeff_square_ff;
         2'd1:    coeff_sel = coeff_linear_ff;
         default: coeff_sel = coeff_constant_ff;
      endcase
   end

   assign add_wide = {prod_ff[63], prod_ff} + {{33{coeff_sel[31]}}, coeff_sel};
   assign mid_sum  = {low_ff[31], low_ff} + {high_ff[31], high_ff};

   assign acc_sign = (acc_ff == '0) ? bcrf_pkg::SIGN_ZERO :
                     (acc_ff[63] ? bcrf_pkg::SIGN_NEG : bcrf_pkg::SIGN_POS);

   assign move_low  = same_sign(low_sign_ff, acc_sign);
   assign move_high = !move_low && same_sign(high_sign_ff, acc_sign);
   assign diff      = {x_ff[31], x_ff} - {prev_ff[31], prev_ff};
   assign diff_abs  = diff[32] ? 33'(-diff) : 33'(diff);
   assign converged = (diff_abs <= {1'b0, tolerance_ff});
   assign at_limit  = (count_ff >= 7'(MAX_ITER));
   assign no_change = same_sign(low_sign_ff, acc_sign);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bcrf_pkg::ST_IDLE:   if (req_take) state_in = bcrf_pkg::ST_MAG;
         bcrf_pkg::ST_MAG:    state_in = bcrf_pkg::ST_MUL_LO;
         bcrf_pkg::ST_MUL_LO: state_in = bcrf_pkg::ST_MUL_HI;
         bcrf_pkg::ST_MUL_HI: state_in = bcrf_pkg::ST_SUM;
         bcrf_pkg::ST_SUM:    state_in = bcrf_pkg::ST_SAT;
         bcrf_pkg::ST_SAT:    state_in = bcrf_pkg::ST_ADD;
         bcrf_pkg::ST_ADD: begin
            state_in = (term_ff == 2'd2) ? bcrf_pkg::ST_DECIDE : bcrf_pkg::ST_MAG;
         end
         bcrf_pkg::ST_DECIDE: begin
            case (eval_ff)
               bcrf_pkg::EV_LOW:  state_in = bcrf_pkg::ST_MAG;
               bcrf_pkg::EV_HIGH: state_in = no_change ? bcrf_pkg::ST_DONE : bcrf_pkg::ST_MID;
               default: begin
                  if (!(move_low || move_high) || converged || at_limit) begin
                     state_in = bcrf_pkg::ST_DONE;
                  end else begin
                     state_in = bcrf_pkg::ST_MID;
                  end
               end
            endcase
         end
         bcrf_pkg::ST_MID:    state_in = bcrf_pkg::ST_MAG;
         bcrf_pkg::ST_DONE:   if (rsp_free) state_in = bcrf_pkg::ST_IDLE;
         default:             state_in = bcrf_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      eval_in      = eval_ff;
      term_in      = term_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      prev_in      = prev_ff;
      x_in         = x_ff;
      xmag_in      = xmag_ff;
      low_sign_in  = low_sign_ff;
      high_sign_in = high_sign_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      step_in      = step_ff;
      root_in      = root_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         bcrf_pkg::ST_IDLE: begin
            if (req_take) begin
               low_in   = req_data.left_end;
               high_in  = req_data.right_end;
               prev_in  = req_data.left_end;
               x_in     = req_data.left_end;
               count_in = '0;
               step_in  = '0;
               eval_in  = bcrf_pkg::EV_LOW;
               term_in  = '0;
               acc_in   = 64'(coeff_cube_ff);
            end
         end
         bcrf_pkg::ST_MAG: begin
            mag_in  = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
            xmag_in = x_ff[31] ? 32'(-x_ff) : 32'(x_ff);
            neg_in  = acc_ff[63] ^ x_ff[31];
         end
         bcrf_pkg::ST_MUL_LO: plo_in = mul_res;
         bcrf_pkg::ST_MUL_HI: phi_in = mul_res;
         bcrf_pkg::ST_SUM: begin
            // floor of a negative quotient: bias the magnitude before the shift
            sum_in = {phi_ff, 32'd0} + {32'd0, plo_ff} + (neg_ff ? ROUND_MASK : 96'd0);
         end
         bcrf_pkg::ST_SAT: begin
            if (neg_ff) begin
               prod_in = q_ovf ? bcrf_pkg::ACC_MIN : -$signed(qmag[63:0]);
            end else begin
               prod_in = q_ovf ? bcrf_pkg::ACC_MAX : $signed(qmag[63:0]);
            end
         end
         bcrf_pkg::ST_ADD: begin
            if (add_wide[64] != add_wide[63]) begin
               acc_in = add_wide[64] ? bcrf_pkg::ACC_MIN : bcrf_pkg::ACC_MAX;
            end else begin
               acc_in = add_wide[63:0];
            end
            term_in = term_ff + 2'd1;
         end
         bcrf_pkg::ST_DECIDE: begin
            case (eval_ff)
               bcrf_pkg::EV_LOW: begin
                  low_sign_in = acc_sign;
                  x_in        = high_ff;
                  eval_in     = bcrf_pkg::EV_HIGH;
                  term_in     = '0;
                  acc_in      = 64'(coeff_cube_ff);
               end
               bcrf_pkg::EV_HIGH: begin
                  high_sign_in = acc_sign;
                  if (no_change) begin
                     root_in   = '0;
                     status_in = bcrf_pkg::STATUS_NO_CHANGE;
                  end
               end
               default: begin
                  if (move_low || move_high) begin
                     if (move_low) begin
                        low_in      = x_ff;
                        low_sign_in = acc_sign;
                     end else begin
                        high_in      = x_ff;
                        high_sign_in = acc_sign;
                     end
                     step_in = diff_abs[31:0];
                     prev_in = x_ff;
                     root_in = x_ff;
                     if (converged) begin
                        status_in = bcrf_pkg::STATUS_CONVERGED;
                     end else if (at_limit) begin
                        status_in = bcrf_pkg::STATUS_ITER_LIMIT;
                     end
                  end else begin
                     // exact zero: keep the step of the previous move
                     root_in   = x_ff;
                     status_in = bcrf_pkg::STATUS_EXACT_ZERO;
                  end
               end
            endcase
         end
         bcrf_pkg::ST_MID: begin
            x_in     = mid_sum[32:1];
            count_in = count_ff + 7'd1;
            eval_in  = bcrf_pkg::EV_MID;
            term_in  = '0;
            acc_in   = 64'(coeff_cube_ff);
         end
         bcrf_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_in.root       = root_ff;
               rsp_in.iterations = count_ff;
               rsp_in.last_step  = step_ff;
               rsp_in.status     = status_ff;
               rsp_valid_in      = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_constant_ff <= bcrf_pkg::COEFF_CONSTANT_RESET;
         coeff_linear_ff   <= bcrf_pkg::COEFF_LINEAR_RESET;
         coeff_square_ff   <= bcrf_pkg::COEFF_SQUARE_RESET;
         coeff_cube_ff     <= bcrf_pkg::COEFF_CUBE_RESET;
         tolerance_ff      <= bcrf_pkg::TOLERANCE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            bcrf_pkg::CSR_COEFF_CONSTANT: coeff_constant_ff <= csr_wdata;
            bcrf_pkg::CSR_COEFF_LINEAR:   coeff_linear_ff   <= csr_wdata;
            bcrf_pkg::CSR_COEFF_SQUARE:   coeff_square_ff   <= csr_wdata;
            bcrf_pkg::CSR_COEFF_CUBE:     coeff_cube_ff     <= csr_wdata;
            bcrf_pkg::CSR_TOLERANCE:      tolerance_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcrf_pkg::ST_IDLE;
         eval_ff      <= bcrf_pkg::EV_LOW;
         term_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eval_ff      <= eval_in;
         term_ff      <= term_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      high_ff      <= high_in;
      prev_ff      <= prev_in;
      x_ff         <= x_in;
      xmag_ff      <= xmag_in;
      low_sign_ff  <= low_sign_in;
      high_sign_ff <= high_sign_in;
      acc_ff       <= acc_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      sum_ff       <= sum_in;
      prod_ff      <= prod_in;
      step_ff      <= step_in;
      root_ff      <= root_in;
      status_ff    <= status_in;
      rsp_ff       <= rsp_in;
   end

   `BCRF_ASSERT_NEXT(a_accept_starts_eval, clock, reset, req_take, state_ff == bcrf_pkg::ST_MAG)
   `BCRF_ASSERT_SAME(a_hi_after_lo, clock, reset, state_ff == bcrf_pkg::ST_MUL_HI, $past(state_ff) == bcrf_pkg::ST_MUL_LO)
   `BCRF_ASSERT_NEXT(a_third_term_decides, clock, reset, state_ff == bcrf_pkg::ST_ADD && term_ff == 2'd2, state_ff == bcrf_pkg::ST_DECIDE)
   `BCRF_ASSERT_SAME(a_count_bounded, clock, reset, 1'b1, count_ff <= 7'(MAX_ITER))
   `BCRF_ASSERT_SAME(a_no_change_empty, clock, reset, rsp_valid_ff && rsp_ff.status == bcrf_pkg::STATUS_NO_CHANGE, rsp_ff.iterations == 7'd0 && rsp_ff.root == 32'sd0)

endmodule

>>> tb/sv/bisection_cubic_root_finder_tb.sv
// Self-checking testbench for the bisection cubic root finder: directed and random searches.
module bisection_cubic_root_finder_tb;

   localparam int FRAC = bcrf_pkg::FRAC_BITS_DEFAULT;
   localparam int STEP_LIMIT = bcrf_pkg::MAX_ITER_DEFAULT;
   localparam logic signed [31:0] ONE = 32'sd65536;
   localparam logic signed [31:0] MOST_NEG = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POS = 32'sh7FFF_FFFF;
   localparam logic [31:0] TOL_MAX = 32'hFFFF_FFFF;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_OFF_CYCLES = 5000;
   localparam int RUN_LIMIT = 100_000_000;

   typedef enum int {STALL_OFF, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_write_enable;
   bcrf_pkg::req_type req_data;
   bcrf_pkg::rsp_type rsp_data;
   logic [bcrf_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [bcrf_pkg::CSR_DATA_WIDTH-1:0] csr_wdata;

   // register copies used by the predictor
   logic signed [31:0] coeff_constant_now = bcrf_pkg::COEFF_CONSTANT_RESET;
   logic signed [31:0] coeff_linear_now = bcrf_pkg::COEFF_LINEAR_RESET;
   logic signed [31:0] coeff_square_now = bcrf_pkg::COEFF_SQUARE_RESET;
   logic signed [31:0] coeff_cube_now = bcrf_pkg::COEFF_CUBE_RESET;
   logic [31:0] tolerance_now = bcrf_pkg::TOLERANCE_RESET;

   bcrf_pkg::rsp_type awaited_solutions[$];
   int mismatches = 0;
   int searches_checked = 0;
   int settings_used = 1;
   int burst_left = 0;
   int hold_cycles = 0;
   int mode_left = 0;
   int outcome_count[4];
   stall_mode_type stall_mode = STALL_OFF;

   bisection_cubic_root_finder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   // floor(acc * x / 2^FRAC), clamped to the 64-bit range
   function automatic logic signed [63:0] scaled_product(logic signed [63:0] acc,
                                                         logic signed [31:0] x);
      logic signed [127:0] wide_acc, wide_x, prod, top, bottom;
      wide_acc = acc;
      wide_x = x;
      top = bcrf_pkg::ACC_MAX;
      bottom = bcrf_pkg::ACC_MIN;
      prod = (wide_acc * wide_x) >>> FRAC;
      if (prod > top)
         return bcrf_pkg::ACC_MAX;
      if (prod < bottom)
         return bcrf_pkg::ACC_MIN;
      return prod[63:0];
   endfunction

   function automatic logic signed [63:0] saturating_sum(logic signed [63:0] a,
                                                         logic signed [63:0] b);
      logic signed [64:0] wide_a, wide_b, total, top, bottom;
      wide_a = a;
      wide_b = b;
      top = bcrf_pkg::ACC_MAX;
      bottom = bcrf_pkg::ACC_MIN;
      total = wide_a + wide_b;
      if (total > top)
         return bcrf_pkg::ACC_MAX;
      if (total < bottom)
         return bcrf_pkg::ACC_MIN;
      return total[63:0];
   endfunction

   function automatic int cubic_sign(logic signed [31:0] x);
      logic signed [63:0] acc;
      acc = coeff_cube_now;
      acc = saturating_sum(scaled_product(acc, x), coeff_square_now);
      acc = saturating_sum(scaled_product(acc, x), coeff_linear_now);
      acc = saturating_sum(scaled_product(acc, x), coeff_constant_now);
      return acc > 0 ? 1 : (acc < 0 ? -1 : 0);
   endfunction

   function automatic bcrf_pkg::rsp_type solve_interval(bcrf_pkg::req_type item);
      bcrf_pkg::rsp_type result;
      logic signed [31:0] lo, hi, prev, mid;
      logic signed [32:0] sum, delta;
      logic [31:0] step;
      logic [1:0] outcome;
      int lo_sign, hi_sign, mid_sign, count;
      bit done;
      lo = item.left_end;
      hi = item.right_end;
      prev = lo;
      mid = '0;
      step = '0;
      count = 0;
      outcome = bcrf_pkg::STATUS_CONVERGED;
      lo_sign = cubic_sign(lo);
      hi_sign = cubic_sign(hi);
      done = (lo_sign * hi_sign > 0);
      if (done)
         outcome = bcrf_pkg::STATUS_NO_CHANGE;
      while (!done) begin
         count++;
         sum = {lo[31], lo} + {hi[31], hi};
         mid = sum[32:1];
         mid_sign = cubic_sign(mid);
         if (lo_sign * mid_sign > 0) begin
            lo = mid;
            lo_sign = mid_sign;
         end else if (mid_sign * hi_sign > 0) begin
            hi = mid;
            hi_sign = mid_sign;
         end else begin
            outcome = bcrf_pkg::STATUS_EXACT_ZERO;
            done = 1'b1;
         end
         if (!done) begin
            delta = {mid[31], mid} - {prev[31], prev};
            step = delta[32] ? 32'(-delta) : delta[31:0];
            prev = mid;
            if (step <= tolerance_now) begin
               outcome = bcrf_pkg::STATUS_CONVERGED;
               done = 1'b1;
            end else if (count >= STEP_LIMIT) begin
               outcome = bcrf_pkg::STATUS_ITER_LIMIT;
               done = 1'b1;
            end
         end
      end
      result.root = mid;
      result.iterations = count[6:0];
      result.last_step = step;
      result.status = outcome;
      return result;
   endfunction

   function automatic bcrf_pkg::req_type make_interval(logic signed [31:0] a,
                                                       logic signed [31:0] b);
      bcrf_pkg::req_type item;
      item.left_end = a;
      item.right_end = b;
      return item;
   endfunction

   // random value spread over +-2^(bits-1)
   function automatic logic signed [31:0] rand_span(int bits);
      logic signed [31:0] v;
      v = $urandom;
      return v >>> (32 - bits);
   endfunction

   function automatic logic signed [31:0] rand_coeff();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return '0;
         default: return rand_span($urandom_range(8, 22));
      endcase
   endfunction

   function automatic logic [31:0] rand_tolerance();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return TOL_MAX;
         2: return $urandom;
         default: return $urandom_range(1, 4096);
      endcase
   endfunction

   // with bracket set, retry a few times for ends of opposite sign
   function automatic bcrf_pkg::req_type random_interval(bit bracket);
      logic signed [31:0] a, b;
      int tries, width;
      tries = 0;
      do begin
         case ($urandom_range(0, 5))
            0, 1: begin
               a = $urandom;
               b = $urandom;
            end
            2, 3: begin
               width = $urandom_range(4, 26);
               a = rand_span(width);
               b = a + rand_span(width);
            end
            4: begin
               a = rand_span(7);
               b = rand_span(7);
            end
            default: begin
               a = '0;
               b = rand_span($urandom_range(2, 32));
            end
         endcase
         tries++;
      end while (bracket && tries < 4 && cubic_sign(a) * cubic_sign(b) > 0);
      if ($urandom_range(0, 7) == 0)
         return make_interval(b, a);
      return make_interval(a, b);
   endfunction

   task automatic write_register(input logic [bcrf_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         bcrf_pkg::CSR_COEFF_CONSTANT: coeff_constant_now = value;
         bcrf_pkg::CSR_COEFF_LINEAR: coeff_linear_now = value;
         bcrf_pkg::CSR_COEFF_SQUARE: coeff_square_now = value;
         bcrf_pkg::CSR_COEFF_CUBE: coeff_cube_now = value;
         bcrf_pkg::CSR_TOLERANCE: tolerance_now = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // drop valid and wait until every search has reported
   task automatic drain_searches();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_solutions.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_cubic(input logic [31:0] constant_term, input logic [31:0] linear,
                            input logic [31:0] square, input logic [31:0] cube,
                            input logic [31:0] tol);
      drain_searches();
      write_register(bcrf_pkg::CSR_COEFF_CONSTANT, constant_term);
      write_register(bcrf_pkg::CSR_COEFF_LINEAR, linear);
      write_register(bcrf_pkg::CSR_COEFF_SQUARE, square);
      write_register(bcrf_pkg::CSR_COEFF_CUBE, cube);
      write_register(bcrf_pkg::CSR_TOLERANCE, tol);
      settings_used++;
   endtask

   task automatic send_interval(input bcrf_pkg::req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      awaited_solutions.push_back(solve_interval(item));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(50, 400) : $urandom_range(1, 20))
            @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      end
   endtask

   task automatic test_default_cubic();
      send_interval(make_interval(0, 2 * ONE));
      send_interval(make_interval(3 * ONE, 0));
      send_interval(make_interval(-10 * ONE, -9 * ONE));
      send_interval(make_interval(0, 0));
      send_interval(make_interval(MOST_NEG, MOST_POS));
      send_interval(make_interval(MOST_POS, MOST_NEG));
      send_interval(make_interval(-1, 1));
   endtask

   // f(x) = x lands midpoints exactly on zero
   task automatic test_exact_zero();
      set_cubic(0, ONE, 0, 0, 0);
      send_interval(make_interval(-4, 2));
      send_interval(make_interval(0, 0));
      send_interval(make_interval(-ONE, ONE));
      send_interval(make_interval(0, 100));
      send_interval(make_interval(100, 0));
      send_interval(make_interval(-100, 0));
      send_interval(make_interval(MOST_NEG, MOST_POS));
      set_cubic(0, ONE, 0, 0, TOL_MAX);
      send_interval(make_interval(-ONE, 3 * ONE));
   endtask

   task automatic test_saturation();
      set_cubic(MOST_POS, MOST_POS, MOST_POS, MOST_POS, bcrf_pkg::TOLERANCE_RESET);
      send_interval(make_interval(MOST_NEG, MOST_POS));
      send_interval(make_interval(-ONE, ONE));
      send_interval(make_interval(MOST_POS, MOST_NEG));
      set_cubic(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, 0);
      send_interval(make_interval(MOST_NEG, MOST_POS));
      send_interval(make_interval(-ONE, ONE));
      send_interval(make_interval(MOST_POS, MOST_NEG));
      set_cubic(MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, TOL_MAX);
      send_interval(make_interval(MOST_NEG, MOST_POS));
      send_interval(make_interval(-ONE, ONE));
      send_interval(make_interval(MOST_POS, MOST_NEG));
   endtask

   task automatic test_random_searches(input int total);
      int sent, batch;
      sent = 0;
      while (sent < total) begin
         set_cubic(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), rand_tolerance());
         batch = $urandom_range(30, 90);
         if (batch > total - sent)
            batch = total - sent;
         repeat (batch) begin
            send_interval(random_interval($urandom_range(0, 4) != 0));
            sent++;
         end
      end
   endtask

   // hold the output long enough for the block to stall its input, then pause the sender
   task automatic test_backpressure();
      drain_searches();
      @(posedge clock);
      hold_cycles = HOLD_OFF_CYCLES;
      repeat (6) send_interval(random_interval(1'b1));
      drain_searches();
      repeat (12) send_interval(random_interval(1'b1));
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles--;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         case (stall_mode)
            STALL_OFF: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) < 6);
         endcase
      end
   end

   always @(posedge clock) begin : check_solutions
      bcrf_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_solutions.size() == 0) begin
            $error("result with no search pending: root %0d", rsp_data.root);
            mismatches++;
         end else begin
            want = awaited_solutions.pop_front();
            searches_checked++;
            outcome_count[want.status]++;
            if (rsp_data.root !== want.root) begin
               $error("root: expected %0d, got %0d", want.root, rsp_data.root);
               mismatches++;
            end
            if (rsp_data.iterations !== want.iterations) begin
               $error("iterations: expected %0d, got %0d", want.iterations, rsp_data.iterations);
               mismatches++;
            end
            if (rsp_data.last_step !== want.last_step) begin
               $error("last_step: expected %0d, got %0d", want.last_step, rsp_data.last_step);
               mismatches++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #RUN_LIMIT;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_cubic();
      test_exact_zero();
      test_saturation();
      test_random_searches(600);
      test_backpressure();
      drain_searches();
      $display("Ran %0d interval searches under %0d register settings, with gaps and stalls.",
               searches_checked, settings_used);
      $display("Outcomes: %0d converged, %0d exact zero, %0d no sign change, %0d step limit.",
               outcome_count[bcrf_pkg::STATUS_CONVERGED],
               outcome_count[bcrf_pkg::STATUS_EXACT_ZERO],
               outcome_count[bcrf_pkg::STATUS_NO_CHANGE],
               outcome_count[bcrf_pkg::STATUS_ITER_LIMIT]);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
